>>> sv/q2e_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler angle block.
// Has no dependencies. Every RTL file in the project imports it.
package q2e_pkg;

    localparam int SW = 34;   // sine/cosine terms, 2^27 = 1.0
    localparam int CW = 28;   // square-root result width
    localparam int XW = 37;   // CORDIC vector width
    localparam int ZW = 26;   // angle accumulator, 2^-16 degree

    localparam logic signed [SW-1:0] ONE_Q27 = SW'(64'sd134217728);
    localparam logic signed [ZW-1:0] DEG90   = ZW'(32'sd5898240);
    localparam logic signed [ZW-1:0] DEG180  = ZW'(32'sd11796480);
    localparam logic signed [ZW-1:0] LIM_X   = ZW'(32'sd5760);
    localparam logic signed [ZW-1:0] LIM_YZ  = ZW'(32'sd11520);

    typedef struct packed {
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic signed [SW-1:0] sz;
        logic signed [SW-1:0] cz;
        logic [CW-1:0]        cx;
        logic                 pole;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0: r = ZW'(32'sd2949120);
            1: r = ZW'(32'sd1740967);
            2: r = ZW'(32'sd919879);
            3: r = ZW'(32'sd466945);
            4: r = ZW'(32'sd234379);
            5: r = ZW'(32'sd117304);
            6: r = ZW'(32'sd58666);
            7: r = ZW'(32'sd29335);
            8: r = ZW'(32'sd14668);
            9: r = ZW'(32'sd7334);
            10: r = ZW'(32'sd3667);
            11: r = ZW'(32'sd1833);
            12: r = ZW'(32'sd917);
            13: r = ZW'(32'sd458);
            14: r = ZW'(32'sd229);
            15: r = ZW'(32'sd115);
            16: r = ZW'(32'sd57);
            17: r = ZW'(32'sd29);
            18: r = ZW'(32'sd14);
            19: r = ZW'(32'sd7);
            20: r = ZW'(32'sd4);
            21: r = ZW'(32'sd2);
            22: r = ZW'(32'sd1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round half up to 1/64 degree, then saturate to +/- lim.
    function automatic logic signed [ZW-1:0] round_sat(input logic signed [ZW-1:0] a,
                                                       input logic signed [ZW-1:0] lim);
        logic signed [ZW:0] s;
        logic signed [ZW:0] r;
        s = (ZW+1)'(a) + (ZW+1)'(27'sd512);
        r = s >>> 10;
        if (r > (ZW+1)'(lim))
            r = (ZW+1)'(lim);
        if (r < -(ZW+1)'(lim))
            r = -(ZW+1)'(lim);
        return ZW'(r);
    endfunction

endpackage

>>> sv/q2e_front.sv
// Front end: products, sine/cosine terms, pole check and pipelined square root.
// Depends on q2e_pkg. Feeds q2e_fifo.
module q2e_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   quat_w,
    input  logic signed [15:0]   quat_x,
    input  logic signed [15:0]   quat_y,
    input  logic signed [15:0]   quat_z,
    output logic                 push,
    output q2e_pkg::item_t       push_item,
    input  q2e_pkg::fifo_stat_t  stat
);
    import q2e_pkg::*;

    localparam int NSQ = CW;
    localparam int NST = 3 + NSQ;

    logic [NST-1:0] vld_reg;
    logic           en;

    assign en      = !(vld_reg[NST-1] && stat.full);
    assign s_ready = en;
    assign push    = vld_reg[NST-1] && !stat.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    logic signed [31:0] wx_reg, yz_reg, wy_reg, xz_reg, wz_reg, xy_reg, xx_reg, yy_reg, zz_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    item_t                it3_reg;
    logic [54:0]          rem3_reg;
    logic signed [57:0]   sq;

    // Off the pole the x sine fits in 29 signed bits.
    assign sq = $signed(sx_reg[28:0]) * $signed(sx_reg[28:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            wy_reg <= quat_w * quat_y;
            xz_reg <= quat_x * quat_z;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;

            sx_reg <= SW'(wx_reg) - SW'(yz_reg);
            sy_reg <= SW'(wy_reg) + SW'(xz_reg);
            cy_reg <= ONE_Q27 - (SW'(xx_reg) + SW'(yy_reg));
            sz_reg <= SW'(wz_reg) + SW'(xy_reg);
            cz_reg <= ONE_Q27 - (SW'(xx_reg) + SW'(zz_reg));

            it3_reg.sx   <= sx_reg;
            it3_reg.sy   <= sy_reg;
            it3_reg.cy   <= cy_reg;
            it3_reg.sz   <= sz_reg;
            it3_reg.cz   <= cz_reg;
            it3_reg.cx   <= '0;
            it3_reg.pole <= (sx_reg >= ONE_Q27) || (sx_reg <= -ONE_Q27);
            rem3_reg     <= (55'(1) << 54) - sq[54:0];
        end
    end

    // One root bit per stage: shift in two radicand bits, trial-subtract.
    logic [31:0]   r_reg [NSQ];
    logic [CW-1:0] q_reg [NSQ];
    logic [55:0]   v_reg [NSQ];
    item_t         itm_reg [NSQ];

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic [31:0]   r_in;
        logic [CW-1:0] q_in;
        logic [55:0]   v_in;
        item_t         it_in;
        logic [31:0]   r_sh;
        logic [31:0]   trial;

        if (k == 0) begin : g_first
            assign r_in  = '0;
            assign q_in  = '0;
            assign v_in  = {1'b0, rem3_reg};
            assign it_in = it3_reg;
        end else begin : g_next
            assign r_in  = r_reg[k-1];
            assign q_in  = q_reg[k-1];
            assign v_in  = v_reg[k-1];
            assign it_in = itm_reg[k-1];
        end

        assign r_sh  = {r_in[29:0], v_in[55:54]};
        assign trial = 32'({q_in, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (r_sh >= trial) begin
                    r_reg[k] <= r_sh - trial;
                    q_reg[k] <= {q_in[CW-2:0], 1'b1};
                end else begin
                    r_reg[k] <= r_sh;
                    q_reg[k] <= {q_in[CW-2:0], 1'b0};
                end
                v_reg[k]   <= {v_in[53:0], 2'b00};
                itm_reg[k] <= it_in;
            end
        end
    end

    always_comb begin
        push_item    = itm_reg[NSQ-1];
        push_item.cx = q_reg[NSQ-1];
    end

endmodule

>>> sv/q2e_fifo.sv
// Four-word queue between the front end and the CORDIC back end.
// Depends on q2e_pkg.
module q2e_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  q2e_pkg::item_t       push_item,
    input  logic                 pop,
    output q2e_pkg::item_t       head,
    output q2e_pkg::fifo_stat_t  stat
);
    import q2e_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    item_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full && !pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && stat.empty)) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

>>> sv/q2e_cordic.sv
// Pipelined vectoring CORDIC: angle of (xv, yv) in 2^-16 degree.
// Depends on q2e_pkg. Setup and rotation registers advance only while en is high.
module q2e_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [q2e_pkg::SW-1:0] yv,
    input  logic signed [q2e_pkg::SW-1:0] xv,
    output logic signed [q2e_pkg::ZW-1:0] angle
);
    import q2e_pkg::*;

    logic signed [XW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 hold_reg [CORDIC_STEPS+1];

    // Zero sine: fix the angle and hold it. Left half-plane: turn by 90 degrees.
    always_ff @(posedge aclk) begin
        if (en) begin
            hold_reg[0] <= (yv == '0);
            if (yv == '0) begin
                x_reg[0] <= XW'(xv);
                y_reg[0] <= '0;
                z_reg[0] <= (xv >= 0) ? '0 : DEG180;
            end else if (xv < 0) begin
                if (yv > 0) begin
                    x_reg[0] <= XW'(yv);
                    y_reg[0] <= -XW'(xv);
                    z_reg[0] <= DEG90;
                end else begin
                    x_reg[0] <= -XW'(yv);
                    y_reg[0] <= XW'(xv);
                    z_reg[0] <= -DEG90;
                end
            end else begin
                x_reg[0] <= XW'(xv);
                y_reg[0] <= XW'(yv);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                hold_reg[i+1] <= hold_reg[i];
                if (hold_reg[i]) begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end else if (!y_reg[i][XW-1]) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS];

endmodule

>>> sv/q2e_back.sv
// Back end: three CORDIC pipelines, rounding, saturation and the output register.
// Depends on q2e_pkg and q2e_cordic. Pops words from q2e_fifo.
module q2e_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q2e_pkg::item_t       head,
    input  q2e_pkg::fifo_stat_t  stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [13:0]   angle_x,
    output logic signed [14:0]   angle_y,
    output logic signed [14:0]   angle_z,
    output logic                 pole_clamped
);
    import q2e_pkg::*;

    localparam int LAT = CORDIC_STEPS + 1;

    logic                 en;
    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       pole_reg;
    logic [LAT-1:0]       pos_reg;
    logic signed [ZW-1:0] zx, zy, zz;
    logic signed [ZW-1:0] ax, ay, az;
    logic                 m_valid_reg;
    logic signed [13:0]   angle_x_reg;
    logic signed [14:0]   angle_y_reg, angle_z_reg;
    logic                 pole_clamped_reg;

    assign en  = !(m_valid_reg && !m_ready);
    assign pop = en && !stat.empty;

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cx (
        .aclk(aclk), .en(en), .yv(head.sx), .xv(SW'(head.cx)), .angle(zx));
    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cy (
        .aclk(aclk), .en(en), .yv(head.sy), .xv(head.cy), .angle(zy));
    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cz (
        .aclk(aclk), .en(en), .yv(head.sz), .xv(head.cz), .angle(zz));

    always_ff @(posedge aclk) begin
        if (en) begin
            pole_reg <= {pole_reg[LAT-2:0], head.pole};
            pos_reg  <= {pos_reg[LAT-2:0], !head.sx[SW-1]};
        end
    end

    always_comb begin
        ay = round_sat(zy, LIM_YZ);
        az = round_sat(zz, LIM_YZ);
        if (pole_reg[LAT-1])
            ax = pos_reg[LAT-1] ? LIM_X : -LIM_X;
        else
            ax = round_sat(zx, LIM_X);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT-2:0], pop};
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_x_reg      <= ax[13:0];
            angle_y_reg      <= ay[14:0];
            angle_z_reg      <= az[14:0];
            pole_clamped_reg <= pole_reg[LAT-1];
        end
    end

    assign m_valid      = m_valid_reg;
    assign angle_x      = angle_x_reg;
    assign angle_y      = angle_y_reg;
    assign angle_z      = angle_z_reg;
    assign pole_clamped = pole_clamped_reg;

endmodule

>>> sv/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_fifo and q2e_back.

// The block takes one Q1.14 quaternion word per cycle and returns one word of
// Euler angles in 1/64 degree per cycle, sustained, as long as m_ready stays
// high. From input acceptance to m_valid a word passes the product registers,
// which load at the accepting edge, then the sum registers, the pole-check
// register, the square-root stages (one root bit per stage) for the arcsine's
// cosine term, the queue, the CORDIC setup register, CORDIC_STEPS rotation
// stages and the output register. The front end and the CORDIC back end are
// separated by a four-word queue; each side stalls on its own when the other
// cannot take or give a word, and s_ready drops only once the front pipeline
// holds a finished word that the full queue cannot take. When the x sine
// reaches magnitude one, angle_x is pinned to plus or minus 90 degrees and
// pole_clamped is set. Inputs outside the unit range are processed with the
// same arithmetic; the angles saturate to +/-90 degrees (x) or +/-180 (y, z).
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [13:0] m_angle_x,
    output logic signed [14:0] m_angle_y,
    output logic signed [14:0] m_angle_z,
    output logic               m_pole_clamped
);
    import q2e_pkg::*;

    logic       push;
    logic       pop;
    item_t      push_item;
    item_t      head;
    fifo_stat_t stat;

    // Classify and prepare the sine/cosine pairs.
    q2e_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .quat_w(s_quat_w), .quat_x(s_quat_x), .quat_y(s_quat_y), .quat_z(s_quat_z),
        .push(push), .push_item(push_item), .stat(stat));

    // Hold words between the two halves.
    q2e_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item),
        .pop(pop), .head(head), .stat(stat));

    // Run the arctangents and drive the result word.
    q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head(head), .stat(stat), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .angle_x(m_angle_x), .angle_y(m_angle_y), .angle_z(m_angle_z),
        .pole_clamped(m_pole_clamped));

endmodule

>>> sim/tb_quaternion_to_euler_angles_top.sv
// Testbench for quaternion_to_euler_angles_top: drives Q1.14 quaternion words
// with random gaps and stalls, predicts Euler angles in 1/64 degree, checks each word.
// Depends on q2e_pkg (through the block) and the RTL only.
module tb_quaternion_to_euler_angles_top;

    localparam int STEPS   = 16;
    localparam int N_RAND  = 1030;
    localparam longint ONE = 64'sd134217728;
    localparam longint D90 = 64'sd5898240;
    localparam longint D180 = 64'sd11796480;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [13:0] ax;
        logic signed [14:0] ay;
        logic signed [14:0] az;
        logic               pole;
    } euler_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [13:0] m_angle_x;
    logic signed [14:0] m_angle_y, m_angle_z;
    logic               m_pole_clamped;

    quat_t  quat_queue[$];
    euler_t euler_queue[$];
    int     errors;
    int     words_sent;
    int     words_checked;
    int     poles_seen;
    int     send_gap;
    int     recv_gap;
    bit     stim_done;

    quaternion_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle_x(m_angle_x), .m_angle_y(m_angle_y), .m_angle_z(m_angle_z),
        .m_pole_clamped(m_pole_clamped)
    );

    function automatic longint atan_step(int i);
        case (i)
            0: return 2949120;   1: return 1740967;   2: return 919879;
            3: return 466945;    4: return 234379;    5: return 117304;
            6: return 58666;     7: return 29335;     8: return 14668;
            9: return 7334;      10: return 3667;     11: return 1833;
            12: return 917;      13: return 458;      14: return 229;
            15: return 115;      16: return 57;       17: return 29;
            18: return 14;       19: return 7;        20: return 4;
            21: return 2;        22: return 1;
            default: return 0;
        endcase
    endfunction

    // Vectoring CORDIC: angle of (cv, sv) in 2^-16 degree.
    function automatic longint vector_angle(longint sv, longint cv);
        longint vx, vy, acc, dx, dy;
        if (sv == 0)
            return (cv >= 0) ? 0 : D180;
        acc = 0;
        vx = cv;
        vy = sv;
        if (cv < 0) begin
            if (sv > 0) begin
                vx = sv; vy = -cv; acc = D90;
            end else begin
                vx = -sv; vy = cv; acc = -D90;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += atan_step(i);
            end else begin
                vx -= dx; vy += dy; acc -= atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint to_degrees64(longint a, longint lim);
        longint r;
        r = (a + 512) >>> 10;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w, x, y, z, sx, sy, cy, sz, cz;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        sx = w * x - y * z;
        sy = w * y + x * z;
        cy = ONE - (x * x + y * y);
        sz = w * z + x * y;
        cz = ONE - (x * x + z * z);
        if (sx >= ONE || sx <= -ONE) begin
            e.ax = (sx > 0) ? 14'sd5760 : -14'sd5760;
            e.pole = 1'b1;
        end else begin
            e.ax = 14'(to_degrees64(vector_angle(sx,
                        root_floor((64'sd1 << 54) - sx * sx)), 5760));
            e.pole = 1'b0;
        end
        e.ay = 15'(to_degrees64(vector_angle(sy, cy), 11520));
        e.az = 15'(to_degrees64(vector_angle(sz, cz), 11520));
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Random unit quaternion scaled to Q1.14, direction drawn from a cube.
    function automatic quat_t rand_unit();
        real a, b, c, d, n;
        quat_t q;
        a = $itor($signed($urandom_range(2000)) - 1000);
        b = $itor($signed($urandom_range(2000)) - 1000);
        c = $itor($signed($urandom_range(2000)) - 1000);
        d = $itor($signed($urandom_range(2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
            a = 1.0; n = 1.0;
        end
        q.w = 16'($rtoi(a / n * 16384.0));
        q.x = 16'($rtoi(b / n * 16384.0));
        q.y = 16'($rtoi(c / n * 16384.0));
        q.z = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Reset: hold low from time zero, then release for good.
    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Fill the stimulus queue: directed corners first, then random words.
    initial begin
        quat_t q;
        int    kind;
        // Identity and its negation.
        quat_queue.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        quat_queue.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        // Half turns about each axis: negative cosine terms, zero sine.
        quat_queue.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        // Pole edge, both signs: 11586 drives the x sine past one, 11585 stays below.
        quat_queue.push_back('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd11585, -16'sd11585, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd11586, 16'sd11586, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd11586, -16'sd11586, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd11584, 16'sd11585, 16'sd0, 16'sd0});
        // Pole reached through the y*z term.
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd11586, -16'sd11586});
        // Non-unit extremes: saturation and large products.
        quat_queue.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        quat_queue.push_back('{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
        quat_queue.push_back('{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384});
        quat_queue.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        quat_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        quat_queue.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        // Tiny angles and sign flips near the negative cosine boundary.
        quat_queue.push_back('{16'sd16384, 16'sd1, -16'sd1, 16'sd1});
        quat_queue.push_back('{16'sd1, 16'sd11585, -16'sd1, 16'sd11585});
        quat_queue.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
        quat_queue.push_back('{16'sd11585, 16'sd0, 16'sd0, -16'sd11585});
        for (int i = 0; i < N_RAND; i++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                q = rand_unit();
            end else if (kind < 8) begin
                // Near a pole: w close to +/-x, small y and z.
                q.w = 16'sd11585 + 16'($signed($urandom_range(40)) - 20);
                q.x = $urandom_range(1) ? q.w : -q.w;
                q.y = 16'($signed($urandom_range(60)) - 30);
                q.z = 16'($signed($urandom_range(60)) - 30);
                if ($urandom_range(1)) q.w = -q.w;
            end else if (kind == 8) begin
                q.w = rand_comp(); q.x = rand_comp();
                q.y = rand_comp(); q.z = rand_comp();
            end else begin
                q = quat_t'({$urandom, $urandom});
            end
            quat_queue.push_back(q);
        end
    end

    // Driver: present each pending word after a random gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_quat_w <= '0;
            s_quat_x <= '0;
            s_quat_y <= '0;
            s_quat_z <= '0;
            send_gap <= $urandom_range(16);
        end else begin
            if (s_valid && s_ready) begin
                euler_queue.push_back(euler_of(quat_t'({s_quat_w, s_quat_x,
                                                        s_quat_y, s_quat_z})));
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                // Slot is free this cycle: hold off for the drawn gap, then load.
                if (send_gap > 0 || quat_queue.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                    else if (!stim_done && words_sent > 0)
                        stim_done <= 1'b1;
                end else begin
                    s_valid  <= 1'b1;
                    {s_quat_w, s_quat_x, s_quat_y, s_quat_z} <= quat_queue.pop_front();
                    // Draw zero gaps often so back-to-back stretches occur.
                    send_gap <= $urandom_range(3) == 0 ? $urandom_range(16) : 0;
                end
            end
        end
    end

    // Monitor: stall m_ready at random and check each accepted word.
    always @(posedge aclk) begin
        euler_t exp_e;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= $urandom_range(16);
        end else begin
            if (m_valid && m_ready) begin
                if (euler_queue.size() == 0) begin
                    $display("%0t: unexpected word ax=%0d ay=%0d az=%0d pole=%0b", $time,
                             m_angle_x, m_angle_y, m_angle_z, m_pole_clamped);
                    errors <= errors + 1;
                end else begin
                    exp_e = euler_queue.pop_front();
                    if (exp_e != {m_angle_x, m_angle_y, m_angle_z, m_pole_clamped}) begin
                        $display("%0t: mismatch expected ax=%0d ay=%0d az=%0d pole=%0b",
                                 $time, exp_e.ax, exp_e.ay, exp_e.az, exp_e.pole);
                        $display("%0t:          actual   ax=%0d ay=%0d az=%0d pole=%0b",
                                 $time, m_angle_x, m_angle_y, m_angle_z, m_pole_clamped);
                        errors <= errors + 1;
                    end
                    if (exp_e.pole)
                        poles_seen <= poles_seen + 1;
                end
                words_checked <= words_checked + 1;
            end
            // Drop ready for a drawn number of cycles after each word.
            if (recv_gap > 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    recv_gap <= $urandom_range(2) == 0 ? $urandom_range(16) : 0;
            end
        end
    end

    initial begin
        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        poles_seen    = 0;
        stim_done     = 1'b0;
        wait (stim_done && !s_valid);
        wait (euler_queue.size() == 0);
        // Let any stray word surface past the pipeline latency.
        repeat (100) @(posedge aclk);
        $display("Sent %0d quaternion words, checked %0d angle words, %0d at the pole.",
                 words_sent, words_checked, poles_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #600000;
        $display("Timeout with %0d words outstanding", euler_queue.size());
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/q2e_pkg.sv
sv/q2e_front.sv
sv/q2e_fifo.sv
sv/q2e_cordic.sv
sv/q2e_back.sv
sv/quaternion_to_euler_angles_top.sv
sim/tb_quaternion_to_euler_angles_top.sv
